// ----- src/aes128_cbc_cipher_defines.svh -----
// ----------------------------------------------------------------------------
// aes128 cbc cipher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_CIPHER_DEFINES_SVH
`define AES128_CBC_CIPHER_DEFINES_SVH

// condition and consequence in the same cycle
`define ACC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence in the cycle after the condition
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/acc_pkg.sv -----
// ----------------------------------------------------------------------------
// acc_pkg
// aes-128 tables, round functions, padding helpers and shared types
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam int AES_ROUNDS = 10;
  localparam int RND_W = 4;
  localparam int ADDR_W = 6;

  // register indexes
  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  // command bundle from controller to datapath
  typedef struct packed {
    logic             key_init;
    logic             kexp_step;
    logic             load;
    logic             load_pad;
    logic             step;
    logic             emit;
    logic             hold_last;
    logic [RND_W-1:0] rnd;
  } acc_cmd_t;

  // status bundle from datapath to controller
  typedef struct packed {
    logic full_pad;
  } acc_sts_t;

  typedef struct packed {
    logic [4:0] keep;
    logic       err;
  } acc_pad_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // round constant for key schedule step i
  function automatic logic [7:0] rcon(input logic [RND_W-1:0] i);
    logic [7:0] r;
    case (i)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // forward key schedule step
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // backward key schedule step
  function automatic logic [127:0] key_inv(input logic [127:0] n, input logic [7:0] rc);
    logic [31:0] k0, k1, k2, k3;
    k3 = n[31:0] ^ n[63:32];
    k2 = n[63:32] ^ n[95:64];
    k1 = n[95:64] ^ n[127:96];
    k0 = n[127:96] ^ sub_word({k3[23:0], k3[31:24]}) ^ {rc, 24'h0};
    return {k0, k1, k2, k3};
  endfunction

  // sub bytes then shift rows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  // inverse shift rows then inverse sub bytes
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  // inverse mix: multiply by 14, 11, 13, 9 from doubling chains
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   m2 [4];
    logic [7:0]   m4 [4];
    logic [7:0]   m8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]   = s[127-32*c-8*j -: 8];
        m2[j]  = xt(a[j]);
        m4[j]  = xt(m2[j]);
        m8[j]  = xt(m4[j]);
        m9[j]  = m8[j] ^ a[j];
        m11[j] = m9[j] ^ m2[j];
        m13[j] = m9[j] ^ m4[j];
        m14[j] = m8[j] ^ m4[j] ^ m2[j];
      end
      t[127-32*c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[119-32*c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[111-32*c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[103-32*c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

  // pkcs7 fill from byte v onward, v already limited to 16
  function automatic logic [127:0] pad_fill(input logic [127:0] b, input logic [4:0] v);
    logic [127:0] t;
    logic [7:0]   pv;
    pv = 8'd16 - {3'b000, v};
    t  = b;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= v) t[127-8*i -: 8] = pv;
    end
    return t;
  endfunction

  // pkcs7 check on a decrypted final block
  function automatic acc_pad_t pad_check(input logic [127:0] b);
    acc_pad_t   res;
    logic [7:0] p;
    logic       ok;
    p  = b[7:0];
    ok = (p >= 8'd1) && (p <= 8'd16);
    for (int i = 0; i < 16; i++) begin
      if ((8'(i) >= 8'd16 - p) && (b[127-8*i -: 8] != p)) ok = 1'b0;
    end
    res.err  = !ok;
    res.keep = ok ? 5'(8'd16 - p) : 5'd0;
    return res;
  endfunction

endpackage

// ----- src/acc_ctrl.sv -----
// ----------------------------------------------------------------------------
// acc_ctrl
// sequencer for key expansion, block rounds and result handoff
// ----------------------------------------------------------------------------
module acc_ctrl
  import acc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     key_wr,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  acc_sts_t sts,
  output acc_cmd_t cmd
);

  localparam logic [2:0] S_KINIT = 3'd0;
  localparam logic [2:0] S_KEXP  = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(AES_ROUNDS);

  logic [2:0]       state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             pend_r, pend_nxt;
  logic             ovalid_r, ovalid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_KINIT: begin
        cmd.key_init = 1'b1;
        rnd_nxt      = RND_W'(1);
        state_nxt    = S_KEXP;
      end
      S_KEXP: begin
        cmd.kexp_step = 1'b1;
        rnd_nxt       = rnd_r + RND_W'(1);
        if (rnd_r == LAST_RND) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          pend_nxt  = sts.full_pad;
          rnd_nxt   = RND_W'(1);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        rnd_nxt  = rnd_r + RND_W'(1);
        if (rnd_r == LAST_RND) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.emit      = 1'b1;
          cmd.hold_last = pend_r;
          if (pend_r) begin
            cmd.load_pad = 1'b1;
            pend_nxt     = 1'b0;
            rnd_nxt      = RND_W'(1);
            state_nxt    = S_RUN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_KINIT;
    endcase
    // a key write restarts the schedule
    if (key_wr) state_nxt = S_KINIT;
  end

  // output valid flag
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.emit) ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_KINIT;
      rnd_r    <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

// ----- src/acc_datapath.sv -----
// ----------------------------------------------------------------------------
// acc_datapath
// one aes round per cycle, on-the-fly round keys, cbc chain and padding
// ----------------------------------------------------------------------------
module acc_datapath
  import acc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  acc_cmd_t       cmd,
  output acc_sts_t       sts,
  input  logic [127:0]   key,
  input  logic [127:0]   iv,
  input  logic           decrypt_mode,
  input  logic [127:0]   in_block,
  input  logic [4:0]     in_valid_bytes,
  input  logic           in_first,
  input  logic           in_last,
  output logic [127:0]   out_block,
  output logic [4:0]     out_keep,
  output logic           out_err,
  output logic           out_last
);

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(AES_ROUNDS);
  localparam logic [RND_W-1:0] INV_BASE = RND_W'(AES_ROUNDS + 1);

  logic [127:0] s_r, rk_r, lastkey_r, chain_r, cprev_r;
  logic         dec_r, last_r;
  logic [127:0] obuf_r;
  logic [4:0]   okeep_r;
  logic         oerr_r, olast_r;

  logic [4:0]   vsat;
  logic [127:0] chain_src, enc_in;
  logic [127:0] fwd_rk, inv_rk, enc_s, dec_t, dec_s, dec_res;
  acc_pad_t     chk;

  // input conditioning
  assign vsat      = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;
  assign chain_src = in_first ? iv : chain_r;
  assign enc_in    = in_last ? pad_fill(in_block, vsat) : in_block;
  assign sts.full_pad = !decrypt_mode && in_last && (vsat == 5'd16);

  // round logic
  assign fwd_rk  = key_fwd(rk_r, rcon(cmd.rnd));
  assign inv_rk  = key_inv(rk_r, rcon(INV_BASE - cmd.rnd));
  assign enc_s   = (cmd.rnd == LAST_RND) ? (sub_shift(s_r) ^ fwd_rk)
                                          : (mix(sub_shift(s_r)) ^ fwd_rk);
  assign dec_t   = inv_shift_sub(s_r) ^ inv_rk;
  assign dec_s   = (cmd.rnd == LAST_RND) ? dec_t : inv_mix(dec_t);
  assign dec_res = s_r ^ cprev_r;
  assign chk     = pad_check(dec_res);

  // chain: cleared by reset, ciphertext on decrypt load, result on encrypt emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (cmd.load && decrypt_mode) begin
      chain_r <= in_block;
    end else if (cmd.emit && !dec_r) begin
      chain_r <= s_r;
    end
  end

  // state and round key
  always_ff @(posedge clk) begin
    if (cmd.key_init) rk_r <= key;
    if (cmd.kexp_step) begin
      rk_r <= fwd_rk;
      if (cmd.rnd == LAST_RND) lastkey_r <= fwd_rk;
    end
    if (cmd.load) begin
      dec_r  <= decrypt_mode;
      last_r <= in_last;
      if (decrypt_mode) begin
        s_r     <= in_block ^ lastkey_r;
        rk_r    <= lastkey_r;
        cprev_r <= chain_src;
      end else begin
        s_r  <= enc_in ^ chain_src ^ key;
        rk_r <= key;
      end
    end
    if (cmd.step) begin
      if (dec_r) begin
        s_r  <= dec_s;
        rk_r <= inv_rk;
      end else begin
        s_r  <= enc_s;
        rk_r <= fwd_rk;
      end
    end
    // emit; a pending pad block chains from the ciphertext just finished
    if (cmd.emit) begin
      olast_r <= last_r && !cmd.hold_last;
      if (dec_r) begin
        obuf_r  <= dec_res;
        okeep_r <= last_r ? chk.keep : 5'd16;
        oerr_r  <= last_r && chk.err;
      end else begin
        obuf_r  <= s_r;
        okeep_r <= 5'd16;
        oerr_r  <= 1'b0;
      end
    end
    if (cmd.load_pad) begin
      s_r  <= {16{8'h10}} ^ s_r ^ key;
      rk_r <= key;
    end
  end

  assign out_block = obuf_r;
  assign out_keep  = okeep_r;
  assign out_err   = oerr_r;
  assign out_last  = olast_r;

endmodule

// ----- src/aes128_cbc_cipher.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_cipher
// aes-128 cbc with pkcs7 padding on encrypt and padding check on decrypt
// ----------------------------------------------------------------------------
// One 16-byte block is processed at a time by a single round unit that does
// one AES round per cycle, with round keys derived on the fly. A block runs
// its 10 rounds and its result is then registered for output; the next
// block is accepted only after that result has been registered. An
// encrypt last block with 16 valid bytes is followed by an extra pad block.
// A stalled result holds the next block back until it has been taken. After
// reset and after every key write the block derives the final round key
// before in_tready rises. The chain is cleared by reset, and the IV takes
// its place for any block flagged first in in_tuser.
module aes128_cbc_cipher
  import acc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [135:0]      in_tdata,  // block_high, block_low, valid_bytes, zero fill
  input  logic              in_tuser,  // first_block
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [135:0]      out_tdata, // out_high, out_low, keep_bytes, zero fill
  output logic              out_tuser, // pad_error
  output logic              out_tlast
);

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        mode_r;
  logic        wr_en, key_wr;
  logic [2:0]  idx;
  acc_cmd_t    cmd;
  acc_sts_t    sts;
  logic [127:0] res_block;
  logic [4:0]   res_keep;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign key_wr     = wr_en && ((idx == REG_KEY_HIGH) || (idx == REG_KEY_LOW));

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
      mode_r     <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_HIGH: key_high_r <= cfg_pwdata;
        REG_KEY_LOW:  key_low_r  <= cfg_pwdata;
        REG_IV_HIGH:  iv_high_r  <= cfg_pwdata;
        REG_IV_LOW:   iv_low_r   <= cfg_pwdata;
        REG_MODE:     mode_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      REG_KEY_HIGH: cfg_prdata = key_high_r;
      REG_KEY_LOW:  cfg_prdata = key_low_r;
      REG_IV_HIGH:  cfg_prdata = iv_high_r;
      REG_IV_LOW:   cfg_prdata = iv_low_r;
      REG_MODE:     cfg_prdata = {63'h0, mode_r};
      default:      cfg_prdata = '0;
    endcase
  end

  acc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_wr     (key_wr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  acc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .key            ({key_high_r, key_low_r}),
    .iv             ({iv_high_r, iv_low_r}),
    .decrypt_mode   (mode_r),
    .in_block       ({in_tdata[63:0], in_tdata[127:64]}),
    .in_valid_bytes (in_tdata[132:128]),
    .in_first       (in_tuser),
    .in_last        (in_tlast),
    .out_block      (res_block),
    .out_keep       (res_keep),
    .out_err        (out_tuser),
    .out_last       (out_tlast)
  );

  assign out_tdata = {3'b000, res_keep, res_block[63:0], res_block[127:64]};

endmodule

// ----- src/acc_checker.sv -----
// ----------------------------------------------------------------------------
// acc_checker
// port-level checks for the aes128 cbc cipher, bound to the top level
// ----------------------------------------------------------------------------
`include "aes128_cbc_cipher_defines.svh"

module acc_checker
  import acc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [ADDR_W-1:0] cfg_paddr,
  input logic [63:0]       cfg_pwdata,
  input logic [63:0]       cfg_prdata,
  input logic              cfg_pready,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [135:0]      in_tdata,
  input logic              in_tuser,
  input logic              in_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [135:0]      out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  // a stalled result holds
  `ACC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // one block in flight: input closes right after a transfer
  `ACC_ASSERT_NEXT(a_one_block, in_tvalid && in_tready, !in_tready, "input open after transfer")

  // a padding error only on a final block, with nothing kept
  `ACC_ASSERT_SAME(a_pad_err, out_tvalid && out_tuser, out_tlast && (out_tdata[132:128] == 5'd0), "bad pad error result")

  // keep count never exceeds a block
  `ACC_ASSERT_SAME(a_keep_range, out_tvalid, out_tdata[132:128] <= 5'd16, "keep count out of range")

endmodule

bind aes128_cbc_cipher acc_checker u_acc_checker (.*);
